// ===== design/rqa_pkg.sv =====
// -----------------------------------------------------------------------------
// rqa_pkg
// Shared types and constants for the RED queue admission block.
// -----------------------------------------------------------------------------
package rqa_pkg;

   localparam int NUM_QUEUES  = 32;
   localparam int QIDX_W      = $clog2(NUM_QUEUES);
   localparam int QUEUE_DEPTH = 4096;
   localparam int LEN_W       = 13;
   localparam int WS_W        = 4;
   localparam int PROB_W      = 16;
   localparam int RND_W       = 16;
   localparam int TIME_W      = 64;
   localparam int AVG_W       = 28;
   localparam int OUT_AVG_W   = 27;
   localparam int CNT_W       = 16;
   localparam int PROD_W      = AVG_W + PROB_W;
   localparam int CPROD_W     = CNT_W + PROB_W + 1;
   localparam int DEN_W       = CPROD_W + 1;
   localparam int FIFO_DEPTH  = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PROB_W-1:0]       PROB_ONE  = '1;
   localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [CNT_W-1:0] COUNT_RST = '1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PROB = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ECN      = 3'd5;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_MARK   = 2'd1,
      VERDICT_DROP   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [LEN_W-1:0]  min_th;
      logic [LEN_W-1:0]  max_th;
      logic [WS_W-1:0]   ws;
      logic [PROB_W-1:0] max_prob;
      logic [LEN_W-1:0]  capacity;
      logic              ecn;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [QIDX_W-1:0] qidx;
      logic [LEN_W-1:0]  qlen;
      logic              empty;
      logic [TIME_W-1:0] idle;
      logic [RND_W-1:0]  rnd;
      logic              forced;
   } item_type;

endpackage

// ===== design/rqa_front.sv =====
// -----------------------------------------------------------------------------
// rqa_front
// Intake stage: capture a request beat, classify it (forced drop, idle ticks)
// and push it into the work queue.
// -----------------------------------------------------------------------------
module rqa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rqa_pkg::QIDX_W-1:0]    req_queue_index,
   input  logic [rqa_pkg::LEN_W-1:0]     req_queue_length,
   input  logic                          req_queue_is_empty,
   input  logic [rqa_pkg::TIME_W-1:0]    req_now_time,
   input  logic [rqa_pkg::TIME_W-1:0]    req_empty_since_time,
   input  logic [rqa_pkg::RND_W-1:0]     req_random_value,
   input  logic [rqa_pkg::LEN_W-1:0]     capacity,
   input  logic                          fifo_full,
   output logic                          push,
   output rqa_pkg::item_type             push_item
);

   logic                       stage_valid_ff, stage_valid_in;
   logic                       accept;
   logic [rqa_pkg::QIDX_W-1:0] qidx_ff;
   logic [rqa_pkg::LEN_W-1:0]  qlen_ff;
   logic                       empty_ff;
   logic [rqa_pkg::TIME_W-1:0] now_ff, since_ff;
   logic [rqa_pkg::RND_W-1:0]  rnd_ff;

   // hold off only when the stage is full and cannot drain
   assign busy   = stage_valid_ff & fifo_full;
   assign accept = start & ~busy;
   assign push   = stage_valid_ff & ~fifo_full;
   assign stage_valid_in = accept | (stage_valid_ff & ~push);

   // classify the staged beat
   always_comb begin
      push_item.qidx   = qidx_ff;
      push_item.qlen   = qlen_ff;
      push_item.empty  = empty_ff;
      push_item.idle   = now_ff - since_ff;
      push_item.rnd    = rnd_ff;
      push_item.forced = (qlen_ff >= capacity);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         qidx_ff  <= req_queue_index;
         qlen_ff  <= req_queue_length;
         empty_ff <= req_queue_is_empty;
         now_ff   <= req_now_time;
         since_ff <= req_empty_since_time;
         rnd_ff   <= req_random_value;
      end
   end

endmodule

// ===== design/rqa_fifo.sv =====
// -----------------------------------------------------------------------------
// rqa_fifo
// Short work queue between the front and back stages.
// -----------------------------------------------------------------------------
module rqa_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rqa_pkg::item_type push_item,
   input  logic              pop,
   output rqa_pkg::item_type head_item,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = $clog2(rqa_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(rqa_pkg::FIFO_DEPTH + 1);

   rqa_pkg::item_type mem_ff [rqa_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(rqa_pkg::FIFO_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(rqa_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(rqa_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/rqa_div.sv =====
// -----------------------------------------------------------------------------
// rqa_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module rqa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rqa_pkg::PROD_W-1:0]  dividend,
   input  logic [rqa_pkg::AVG_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [rqa_pkg::PROD_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(rqa_pkg::PROD_W + 1);

   logic [rqa_pkg::PROD_W-1:0] quo_ff;
   logic [rqa_pkg::AVG_W-1:0]  rem_ff, dsr_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       busy_ff, done_ff;
   logic [rqa_pkg::AVG_W:0]    trial;
   logic                       fits;

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   // shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[rqa_pkg::PROD_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
         step_ff <= STEP_W'(rqa_pkg::PROD_W);
      end else if (busy_ff) begin
         rem_ff  <= fits ? rqa_pkg::AVG_W'(trial - {1'b0, dsr_ff})
                         : trial[rqa_pkg::AVG_W-1:0];
         quo_ff  <= {quo_ff[rqa_pkg::PROD_W-2:0], fits};
         step_ff <= step_ff - 1'b1;
      end
   end

endmodule

// ===== design/rqa_back.sv =====
// -----------------------------------------------------------------------------
// rqa_back
// Execution sequencer: per-queue state, average update, idle decay, drop
// probability and the verdict.
// -----------------------------------------------------------------------------
module rqa_back (
   input  logic                             clock,
   input  logic                             reset,
   input  rqa_pkg::cfg_type                 cfg,
   input  logic                             fifo_empty,
   input  rqa_pkg::item_type                head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_verdict,
   output logic                             rsp_forced,
   output logic [rqa_pkg::OUT_AVG_W-1:0]    rsp_average_scaled
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EWMA, ST_DECAY, ST_CMP, ST_MUL, ST_DIVPB,
      ST_MULCNT, ST_DEN, ST_DIVPA, ST_TEST, ST_FIN
   } state_type;

   state_type                          state_ff;
   rqa_pkg::item_type                  item_ff;
   logic [rqa_pkg::AVG_W-1:0]          avg_mem_ff [rqa_pkg::NUM_QUEUES];
   logic signed [rqa_pkg::CNT_W-1:0]   cnt_mem_ff [rqa_pkg::NUM_QUEUES];
   logic [rqa_pkg::AVG_W-1:0]          avg_ff;
   logic signed [rqa_pkg::CNT_W-1:0]   cnt_ff;
   logic [rqa_pkg::TIME_W-1:0]         idle_ff;
   logic [rqa_pkg::PROD_W-1:0]         prod_ff;
   logic [rqa_pkg::PROB_W-1:0]         pb_ff, pa_ff;
   logic signed [rqa_pkg::CPROD_W-1:0] cprod_ff;
   logic                               hit_ff;
   logic                               rsp_valid_ff, rsp_forced_ff;
   logic [1:0]                         rsp_verdict_ff;
   logic [rqa_pkg::OUT_AVG_W-1:0]      rsp_avg_ff;

   logic [rqa_pkg::AVG_W-1:0]          lo, hi, target, avg_step, decay_avg;
   logic [rqa_pkg::AVG_W:0]            ewma_sum;
   logic [rqa_pkg::AVG_W-1:0]          ewma_avg;
   logic signed [rqa_pkg::CPROD_W-1:0] cnt_ext, pb_ext;
   logic signed [rqa_pkg::DEN_W-1:0]   den;
   logic                               den_pos;
   logic [31:0]                        pa_num;
   logic                               div_start, div_busy, div_done;
   logic [rqa_pkg::PROD_W-1:0]         div_dividend, div_quotient;
   logic [rqa_pkg::AVG_W-1:0]          div_divisor;

   assign pop                = (state_ff == ST_IDLE) && !fifo_empty;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_forced         = rsp_forced_ff;
   assign rsp_average_scaled = rsp_avg_ff;

   // thresholds, average update and decay step
   always_comb begin
      lo        = rqa_pkg::AVG_W'(cfg.min_th) << cfg.ws;
      hi        = rqa_pkg::AVG_W'(cfg.max_th) << cfg.ws;
      target    = rqa_pkg::AVG_W'(item_ff.qlen) << cfg.ws;
      if (target >= avg_ff) begin
         ewma_sum = {1'b0, avg_ff} + {1'b0, (target - avg_ff) >> cfg.ws};
      end else begin
         ewma_sum = {1'b0, avg_ff - ((avg_ff - target) >> cfg.ws)};
      end
      ewma_avg  = ewma_sum[rqa_pkg::AVG_W-1:0];
      avg_step  = avg_ff >> cfg.ws;
      decay_avg = avg_ff - avg_step;
      cnt_ext   = rqa_pkg::CPROD_W'(cnt_ff);
      pb_ext    = $signed({{(rqa_pkg::CPROD_W-rqa_pkg::PROB_W){1'b0}}, pb_ff});
      den       = rqa_pkg::DEN_W'(65535) - {cprod_ff[rqa_pkg::CPROD_W-1], cprod_ff};
      den_pos   = !den[rqa_pkg::DEN_W-1] && (den != '0);
      pa_num    = {pb_ff, 16'h0} - {16'h0, pb_ff};
   end

   // divider operand select
   always_comb begin
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = hi - lo;
      if (state_ff == ST_MUL) begin
         div_start = 1'b1;
      end else if (state_ff == ST_DEN) begin
         div_start    = den_pos;
         div_dividend = rqa_pkg::PROD_W'(pa_num);
         div_divisor  = rqa_pkg::AVG_W'(den[rqa_pkg::AVG_W-1:0]);
      end
   end

   rqa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer, queue state and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rqa_pkg::NUM_QUEUES; i++) begin
            avg_mem_ff[i] <= '0;
            cnt_mem_ff[i] <= rqa_pkg::COUNT_RST;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!fifo_empty) begin
                  item_ff  <= head_item;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               avg_ff  <= avg_mem_ff[item_ff.qidx];
               cnt_ff  <= cnt_mem_ff[item_ff.qidx];
               idle_ff <= item_ff.idle;
               hit_ff  <= 1'b0;
               if (item_ff.forced) begin
                  cnt_mem_ff[item_ff.qidx] <= rqa_pkg::COUNT_RST;
                  rsp_valid_ff   <= 1'b1;
                  rsp_verdict_ff <= rqa_pkg::VERDICT_DROP;
                  rsp_forced_ff  <= 1'b1;
                  rsp_avg_ff     <= avg_mem_ff[item_ff.qidx][rqa_pkg::OUT_AVG_W-1:0];
                  state_ff       <= ST_IDLE;
               end else if (item_ff.empty) begin
                  state_ff <= ST_DECAY;
               end else begin
                  state_ff <= ST_EWMA;
               end
            end
            ST_EWMA: begin
               avg_ff   <= ewma_avg;
               state_ff <= ST_CMP;
            end
            ST_DECAY: begin
               // one tick of decay per cycle until idle runs out or avg is small
               if (idle_ff != '0 && avg_step != '0) begin
                  avg_ff  <= decay_avg;
                  idle_ff <= idle_ff - 1'b1;
               end else begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               avg_mem_ff[item_ff.qidx] <= avg_ff;
               if (avg_ff > hi) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_FIN;
               end else if (avg_ff > lo && hi > lo) begin
                  prod_ff  <= rqa_pkg::PROD_W'(cfg.max_prob) * rqa_pkg::PROD_W'(avg_ff - lo);
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIVPB;
            end
            ST_DIVPB: begin
               if (div_done) begin
                  pb_ff    <= div_quotient[rqa_pkg::PROB_W-1:0];
                  state_ff <= ST_MULCNT;
               end
            end
            ST_MULCNT: begin
               cprod_ff <= cnt_ext * pb_ext;
               state_ff <= ST_DEN;
            end
            ST_DEN: begin
               if (den_pos) begin
                  state_ff <= ST_DIVPA;
               end else begin
                  pa_ff    <= rqa_pkg::PROB_ONE;
                  state_ff <= ST_TEST;
               end
            end
            ST_DIVPA: begin
               if (div_done) begin
                  pa_ff    <= (|div_quotient[rqa_pkg::PROD_W-1:rqa_pkg::PROB_W])
                              ? rqa_pkg::PROB_ONE : div_quotient[rqa_pkg::PROB_W-1:0];
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               hit_ff   <= (item_ff.rnd <= pa_ff);
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (hit_ff) begin
                  cnt_mem_ff[item_ff.qidx] <= '0;
               end else if (cnt_ff < rqa_pkg::COUNT_MAX) begin
                  cnt_mem_ff[item_ff.qidx] <= cnt_ff + 1'b1;
               end
               rsp_valid_ff   <= 1'b1;
               rsp_verdict_ff <= !hit_ff ? rqa_pkg::VERDICT_ACCEPT
                               : (cfg.ecn ? rqa_pkg::VERDICT_MARK : rqa_pkg::VERDICT_DROP);
               rsp_forced_ff  <= 1'b0;
               rsp_avg_ff     <= avg_ff[rqa_pkg::OUT_AVG_W-1:0];
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // no result beat directly follows another
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result beats");

   a_forced_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forced |-> rsp_verdict == rqa_pkg::VERDICT_DROP)
      else $error("forced result without drop verdict");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider restarted while busy");

endmodule

// ===== design/red_queue_admission.sv =====
// -----------------------------------------------------------------------------
// red_queue_admission
// RED admission over 32 queues: EWMA average, idle decay, Floyd probability.
// -----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              req_queue_index .. req_random_value
//  response  rsp_valid (one cycle)     rsp_verdict, rsp_forced, rsp_average_scaled
//  config    csr_write_enable          csr_index, csr_write_data
//
//  A forced drop is answered from the read state. An average update inside the
//  early region runs up to two 44-step passes of the shared divider; one outside
//  it skips the divider. An empty queue decays one tick at a time until the idle
//  count runs out or the average falls below one unit.
//  Reset is synchronous; all queue averages clear and all counts go to -1.
//  busy rises when the intake stage and the two-entry work queue are full.
//  Results cannot be held off by the receiver.
// -----------------------------------------------------------------------------
module red_queue_admission (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rqa_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic [rqa_pkg::LEN_W-1:0]          req_queue_length,
   input  logic                               req_queue_is_empty,
   input  logic [rqa_pkg::TIME_W-1:0]         req_now_time,
   input  logic [rqa_pkg::TIME_W-1:0]         req_empty_since_time,
   input  logic [rqa_pkg::RND_W-1:0]          req_random_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_verdict,
   output logic                               rsp_forced,
   output logic [rqa_pkg::OUT_AVG_W-1:0]      rsp_average_scaled,
   input  logic                               csr_write_enable,
   input  logic [rqa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rqa_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   rqa_pkg::cfg_type  cfg_ff;
   logic              fifo_full, fifo_empty, push, pop;
   rqa_pkg::item_type push_item, head_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_th   <= rqa_pkg::LEN_W'(5);
         cfg_ff.max_th   <= rqa_pkg::LEN_W'(15);
         cfg_ff.ws       <= rqa_pkg::WS_W'(9);
         cfg_ff.max_prob <= rqa_pkg::PROB_W'(6554);
         cfg_ff.capacity <= rqa_pkg::LEN_W'(rqa_pkg::QUEUE_DEPTH);
         cfg_ff.ecn      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            rqa_pkg::CSR_MIN_TH:   cfg_ff.min_th   <= csr_write_data[rqa_pkg::LEN_W-1:0];
            rqa_pkg::CSR_MAX_TH:   cfg_ff.max_th   <= csr_write_data[rqa_pkg::LEN_W-1:0];
            rqa_pkg::CSR_WS:       cfg_ff.ws       <= csr_write_data[rqa_pkg::WS_W-1:0];
            rqa_pkg::CSR_MAX_PROB: cfg_ff.max_prob <= csr_write_data[rqa_pkg::PROB_W-1:0];
            rqa_pkg::CSR_CAPACITY: cfg_ff.capacity <= csr_write_data[rqa_pkg::LEN_W-1:0];
            rqa_pkg::CSR_ECN:      cfg_ff.ecn      <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   rqa_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_queue_index      (req_queue_index),
      .req_queue_length     (req_queue_length),
      .req_queue_is_empty   (req_queue_is_empty),
      .req_now_time         (req_now_time),
      .req_empty_since_time (req_empty_since_time),
      .req_random_value     (req_random_value),
      .capacity             (cfg_ff.capacity),
      .fifo_full            (fifo_full),
      .push                 (push),
      .push_item            (push_item)
   );

   rqa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   rqa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .fifo_empty         (fifo_empty),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_verdict        (rsp_verdict),
      .rsp_forced         (rsp_forced),
      .rsp_average_scaled (rsp_average_scaled)
   );

endmodule

// ===== sim/red_queue_admission_test.sv =====
// -----------------------------------------------------------------------------
// red_queue_admission_test
// Self-checking bench for the RED admission block: a short table of directed
// packets under the reset settings, then random traffic over several register
// settings, each verdict held to a typed row or a cycle-free admission predictor.
// -----------------------------------------------------------------------------
module red_queue_admission_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int ITEMS_PER_SET  = 130;
   localparam int NUM_SETS       = 9;

   typedef struct {
      int unsigned min_th;
      int unsigned max_th;
      int unsigned ws;
      int unsigned max_prob;
      int unsigned capacity;
      int unsigned ecn;
   } red_setting_type;

   typedef struct {
      logic [rqa_pkg::QIDX_W-1:0] qidx;
      logic [rqa_pkg::LEN_W-1:0]  qlen;
      logic                       empty;
      logic [rqa_pkg::TIME_W-1:0] now_t;
      logic [rqa_pkg::TIME_W-1:0] since_t;
      logic [rqa_pkg::RND_W-1:0]  rnd;
   } packet_type;

   typedef struct {
      rqa_pkg::verdict_type          verdict;
      logic                          forced;
      logic [rqa_pkg::OUT_AVG_W-1:0] avg;
   } verdict_beat_type;

   typedef struct {
      packet_type       pkt;
      bit               typed;
      verdict_beat_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rqa_pkg::QIDX_W-1:0]     req_queue_index      = '0;
   logic [rqa_pkg::LEN_W-1:0]      req_queue_length     = '0;
   logic                           req_queue_is_empty   = 1'b0;
   logic [rqa_pkg::TIME_W-1:0]     req_now_time         = '0;
   logic [rqa_pkg::TIME_W-1:0]     req_empty_since_time = '0;
   logic [rqa_pkg::RND_W-1:0]      req_random_value     = '0;
   logic                           rsp_valid;
   logic [1:0]                     rsp_verdict;
   logic                           rsp_forced;
   logic [rqa_pkg::OUT_AVG_W-1:0]  rsp_average_scaled;
   logic                           csr_write_enable = 1'b0;
   logic [rqa_pkg::CSR_IDX_W-1:0]  csr_index        = '0;
   logic [rqa_pkg::CSR_DATA_W-1:0] csr_write_data   = '0;

   red_queue_admission u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   red_setting_type            red_cfg;
   logic [rqa_pkg::AVG_W-1:0]  pred_avg [rqa_pkg::NUM_QUEUES];
   int                         pred_count [rqa_pkg::NUM_QUEUES];

   verdict_beat_type  pending_verdicts [$];
   int unsigned       mismatches;
   int unsigned       packets_sent;
   int unsigned       verdicts_seen;
   int unsigned       early_hits;
   int unsigned       forced_seen;
   int unsigned       idle_cycles;
   bit                allow_gaps;

   // admission decision for one packet; advances the per-queue state
   function automatic verdict_beat_type admit_packet(packet_type p);
      verdict_beat_type  r;
      int unsigned       q;
      longint unsigned   a, lo, hi, unit, idle, pb, pa;
      longint            den;
      bit                hit;
      q    = p.qidx % rqa_pkg::NUM_QUEUES;
      a    = pred_avg[q];
      lo   = longint'(red_cfg.min_th) << red_cfg.ws;
      hi   = longint'(red_cfg.max_th) << red_cfg.ws;
      unit = 64'd1 << red_cfg.ws;
      idle = p.now_t - p.since_t;
      hit  = 1'b0;
      r.forced = 1'b0;
      if (p.qlen >= red_cfg.capacity) begin
         pred_count[q] = -1;
         r.verdict = rqa_pkg::VERDICT_DROP;
         r.forced  = 1'b1;
         r.avg     = a[rqa_pkg::OUT_AVG_W-1:0];
         return r;
      end
      if (!p.empty) begin
         if ((longint'(p.qlen) << red_cfg.ws) >= a)
            a += ((longint'(p.qlen) << red_cfg.ws) - a) >> red_cfg.ws;
         else
            a -= (a - (longint'(p.qlen) << red_cfg.ws)) >> red_cfg.ws;
      end else begin
         while (idle != 0 && a >= unit) begin
            a -= a >> red_cfg.ws;
            idle--;
         end
      end
      a &= 64'hFFF_FFFF;
      pred_avg[q] = a[rqa_pkg::AVG_W-1:0];
      if (a > hi) begin
         hit = 1'b1;
      end else if (a > lo && hi > lo) begin
         pb  = (longint'(red_cfg.max_prob) * (a - lo)) / (hi - lo);
         den = 65535 - longint'(pred_count[q]) * longint'(pb);
         if (den <= 0) begin
            pa = 65535;
         end else begin
            pa = (pb * 65535) / longint'(den);
            if (pa > 65535) pa = 65535;
         end
         hit = (p.rnd <= pa);
      end
      if (hit) begin
         pred_count[q] = -1;
         early_hits++;
      end
      if (pred_count[q] < 32767) pred_count[q]++;
      r.verdict = hit ? (red_cfg.ecn ? rqa_pkg::VERDICT_MARK : rqa_pkg::VERDICT_DROP)
                      : rqa_pkg::VERDICT_ACCEPT;
      r.avg     = a[rqa_pkg::OUT_AVG_W-1:0];
      return r;
   endfunction

   // present one packet and hold it until the block takes it
   task automatic send_packet(packet_type p, bit typed, verdict_beat_type want);
      verdict_beat_type got;
      int gap;
      req_queue_index      <= p.qidx;
      req_queue_length     <= p.qlen;
      req_queue_is_empty   <= p.empty;
      req_now_time         <= p.now_t;
      req_empty_since_time <= p.since_t;
      req_random_value     <= p.rnd;
      start                <= 1'b1;
      do @(posedge clock); while (busy);
      got = admit_packet(p);
      pending_verdicts.push_back(typed ? want : got);
      packets_sent++;
      // random idle burst on the request side
      if (allow_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // write every register once the block has drained
   task automatic load_setting(red_setting_type s);
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         case (i)
            0: begin
               csr_index      <= rqa_pkg::CSR_MIN_TH;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.min_th);
            end
            1: begin
               csr_index      <= rqa_pkg::CSR_MAX_TH;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.max_th);
            end
            2: begin
               csr_index      <= rqa_pkg::CSR_WS;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.ws);
            end
            3: begin
               csr_index      <= rqa_pkg::CSR_MAX_PROB;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.max_prob);
            end
            4: begin
               csr_index      <= rqa_pkg::CSR_CAPACITY;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.capacity);
            end
            default: begin
               csr_index      <= rqa_pkg::CSR_ECN;
               csr_write_data <= rqa_pkg::CSR_DATA_W'(s.ecn);
            end
         endcase
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      red_cfg = s;
   endtask

   function automatic packet_type random_packet();
      packet_type p;
      int unsigned top;
      top = red_cfg.max_th * 2 + 4;
      if (top < red_cfg.min_th + 4) top = red_cfg.min_th + 4;
      if (top > 8191) top = 8191;
      p.qidx = rqa_pkg::QIDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 31));
      p.qlen = rqa_pkg::LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(0, top));
      p.rnd  = rqa_pkg::RND_W'($urandom);
      p.empty   = ($urandom_range(0, 7) == 0);
      p.since_t = {$urandom, $urandom};
      // long idle spans only where ws is 3 or less, so the decay dies out quickly
      if (red_cfg.ws <= 3 && $urandom_range(0, 3) == 0)
         p.now_t = {$urandom, $urandom};
      else
         p.now_t = p.since_t + rqa_pkg::TIME_W'($urandom_range(0, 300));
      return p;
   endfunction

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      verdict_beat_type e;
      if (!reset && rsp_valid) begin
         verdicts_seen++;
         if (rsp_forced) forced_seen++;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected verdict beat: verdict %0d forced %0d avg %0d",
                        rsp_verdict, rsp_forced, rsp_average_scaled);
         end else begin
            e = pending_verdicts.pop_front();
            if (rsp_verdict !== e.verdict || rsp_forced !== e.forced ||
                rsp_average_scaled !== e.avg) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("verdict mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                           e.verdict, e.forced, e.avg,
                           rsp_verdict, rsp_forced, rsp_average_scaled);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || rsp_valid || csr_write_enable || (start && !busy))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("red_queue_admission_test: errors");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [$];
      directed_row_type row;
      red_setting_type  sets [NUM_SETS];
      verdict_beat_type none;
      packet_type       p;

      mismatches    = 0;
      packets_sent  = 0;
      verdicts_seen = 0;
      early_hits    = 0;
      forced_seen   = 0;
      idle_cycles   = 0;
      allow_gaps    = 1'b1;
      none = '{rqa_pkg::VERDICT_ACCEPT, 1'b0, '0};
      red_cfg = '{5, 15, 9, 6554, rqa_pkg::QUEUE_DEPTH, 0};
      for (int i = 0; i < rqa_pkg::NUM_QUEUES; i++) begin
         pred_avg[i]   = '0;
         pred_count[i] = -1;
      end

      sets[0] = '{0, 4096, 0, 65535, 8191, 1};
      sets[1] = '{2, 10, 1, 32768, 64, 0};
      sets[2] = '{10, 10, 2, 1000, 4096, 1};
      sets[3] = '{30, 5, 3, 65535, 40, 0};
      sets[4] = '{4096, 0, 15, 0, 1, 1};
      sets[5] = '{0, 0, 4, 20000, 0, 0};
      sets[6] = '{3, 40, 2, 65535, 4096, 1};
      sets[7] = '{5, 15, 9, 6554, 4096, 0};
      sets[8] = '{1, 8, 0, 300, 30, 0};

      // directed packets under the reset settings
      rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1,
                       '{rqa_pkg::VERDICT_ACCEPT, 1'b0, 27'd0}});
      rows.push_back('{'{31, 4096, 0, '1, '1, 16'hFFFF}, 1,
                       '{rqa_pkg::VERDICT_DROP, 1'b1, 27'd0}});
      rows.push_back('{'{1, 8191, 1, 0, '1, 0}, 1,
                       '{rqa_pkg::VERDICT_DROP, 1'b1, 27'd0}});
      rows.push_back('{'{2, 4095, 0, 0, 0, 16'h0000}, 0, none});
      rows.push_back('{'{2, 4095, 0, 0, 0, 16'hFFFF}, 0, none});
      rows.push_back('{'{2, 4095, 0, 0, 0, 16'h8000}, 0, none});
      rows.push_back('{'{2, 0, 1, 64'd7, 64'd7, 0}, 0, none});
      rows.push_back('{'{2, 0, 1, 64'd0, '1, 0}, 0, none});
      rows.push_back('{'{2, 0, 1, 64'd5, 64'd10, 0}, 0, none});
      rows.push_back('{'{3, 4095, 0, 0, 0, 16'hFFFF}, 0, none});
      rows.push_back('{'{3, 8, 0, 0, 0, 16'h0000}, 0, none});
      rows.push_back('{'{3, 8, 0, 0, 0, 16'h0001}, 0, none});
      rows.push_back('{'{3, 8, 0, 0, 0, 16'hFFFF}, 0, none});
      rows.push_back('{'{3, 4096, 0, 0, 0, 0}, 0, none});
      rows.push_back('{'{4, 15, 0, 0, 0, 0}, 0, none});
      rows.push_back('{'{4, 5, 0, 0, 0, 0}, 0, none});
      rows.push_back('{'{5, 4095, 0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         16'h5555}, 0, none});
      rows.push_back('{'{5, 4095, 0, 0, 0, 16'hAAAA}, 0, none});

      // hold reset, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send_packet(row.pkt, row.typed, row.want);
      end

      // random traffic over each setting; the last set runs without gaps
      for (int s = 0; s < NUM_SETS; s++) begin
         load_setting(sets[s]);
         allow_gaps = (s != NUM_SETS - 1);
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            p = random_packet();
            send_packet(p, 1'b0, none);
         end
      end
      start <= 1'b0;

      // drain, then let any stray beat show up
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d packets over %0d register settings: %0d verdicts, %0d forced,",
               packets_sent, NUM_SETS + 1, verdicts_seen, forced_seen);
      $display("%0d marks or drops from the threshold regions", early_hits);
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("red_queue_admission_test: clean");
      else
         $display("red_queue_admission_test: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rqa_pkg.sv
design/rqa_front.sv
design/rqa_fifo.sv
design/rqa_div.sv
design/rqa_back.sv
design/red_queue_admission.sv
sim/red_queue_admission_test.sv
